### rtl/lsfp_pkg.sv
// Shared constants, codes and control types for the line sensor frame parser.
// Depends on nothing; every other file of the block refers to it by scoped name.
`timescale 1ns / 1ps

package lsfp_pkg;

  localparam int FRAME_BYTES = 96;
  localparam int IDX_W       = $clog2(FRAME_BYTES);

  // Characters of the sensor's ASCII stream
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_EIGHT  = 8'h38;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Number scanner phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PRE   = 2'd1;
  localparam logic [1:0] PH_SIGN  = 2'd2;
  localparam logic [1:0] PH_DIGIT = 2'd3;

  // Channel weights, bit 0 to bit 7
  localparam logic signed [3:0] WEIGHT [8] = '{
    -4'sd7, -4'sd5, -4'sd3, -4'sd1, 4'sd1, 4'sd3, 4'sd5, 4'sd7
  };

  // |sum| is at most 16, so the quotient search takes five bits
  localparam int DIV_STEPS = 5;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic take;       // parser consumes the input byte
    logic div_start;  // capture frame verdict into the offset unit
    logic div_load;   // form sum and count
    logic div_step;   // one quotient bit
    logic out_load;   // move result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit;       // the byte on the input closes a frame
    logic out_free;   // output register can take a result this cycle
  } ctrl_stat_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] bits;
  } frame_res_t;

endpackage

### rtl/lsfp_ctrl.sv
// Controller for the line sensor frame parser: sequences byte intake,
// the offset division and the hand-off to the output register. Uses lsfp_pkg.
`timescale 1ns / 1ps

module lsfp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  lsfp_pkg::ctrl_stat_t stat,
  output lsfp_pkg::ctrl_cmd_t  cmd,
  output logic                 in_stall
);

  typedef enum logic [3:0] {
    ST_RUN  = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [lsfp_pkg::STEP_W-1:0]   step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_RUN: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
        if (in_valid && stat.emit) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == lsfp_pkg::STEP_W'(lsfp_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

### rtl/lsfp_parse.sv
// Byte parser datapath: frame tracking, prefix check, key and number scanning.
// Uses lsfp_pkg; driven by the take command from lsfp_ctrl.
`timescale 1ns / 1ps

module lsfp_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lsfp_pkg::ctrl_cmd_t  cmd,
  input  logic [7:0]           rx_byte,
  output logic                 emit,
  output lsfp_pkg::frame_res_t res
);

  logic                       in_frame_r, in_frame_nxt;
  logic [lsfp_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       prefix_r, prefix_nxt;
  logic                       ended_r, ended_nxt;
  logic [15:0]                prev_r, prev_nxt;
  logic [7:0]                 found_r, found_nxt;
  logic [7:0]                 zero_r, zero_nxt;
  logic [7:0]                 bad_r, bad_nxt;
  logic [1:0]                 phase_r, phase_nxt;
  logic [2:0]                 key_r, key_nxt;
  logic                       nz_r, nz_nxt;

  // state as seen by this byte ('$' restarts the frame)
  logic                       in_frame_c;
  logic [lsfp_pkg::IDX_W-1:0] idx_c;
  logic                       prefix_c, ended_c, nz_c;
  logic [15:0]                prev_c;
  logic [7:0]                 found_c, zero_c, bad_c;
  logic [1:0]                 phase_c;
  logic [2:0]                 key_c;

  logic       is_start, is_ws, is_sign, is_digit, end_num, key_hit;
  logic [2:0] new_key;
  logic [7:0] act_bit, new_bit;

  always_comb begin
    is_start = (rx_byte == lsfp_pkg::CH_DOLLAR);
    if (is_start) begin
      in_frame_c = 1'b1;
      idx_c      = '0;
      prefix_c   = 1'b1;
      ended_c    = 1'b0;
      prev_c     = '0;
      found_c    = '0;
      zero_c     = '0;
      bad_c      = '0;
      phase_c    = lsfp_pkg::PH_IDLE;
      key_c      = '0;
      nz_c       = 1'b0;
    end else begin
      in_frame_c = in_frame_r;
      idx_c      = idx_r;
      prefix_c   = prefix_r;
      ended_c    = ended_r;
      prev_c     = prev_r;
      found_c    = found_r;
      zero_c     = zero_r;
      bad_c      = bad_r;
      phase_c    = phase_r;
      key_c      = key_r;
      nz_c       = nz_r;
    end

    is_ws    = (rx_byte == lsfp_pkg::CH_SPACE) ||
               (rx_byte >= lsfp_pkg::CH_TAB && rx_byte <= lsfp_pkg::CH_CR);
    is_sign  = (rx_byte == lsfp_pkg::CH_PLUS) || (rx_byte == lsfp_pkg::CH_MINUS);
    is_digit = (rx_byte >= lsfp_pkg::CH_ZERO) && (rx_byte <= lsfp_pkg::CH_NINE);
    new_key  = 3'(prev_c[7:0] - lsfp_pkg::CH_ONE);
    new_bit  = 8'b1 << new_key;
    act_bit  = 8'b1 << key_c;
    key_hit  = !ended_c && (rx_byte == lsfp_pkg::CH_COLON) &&
               (prev_c[15:8] == lsfp_pkg::CH_X) &&
               (prev_c[7:0] >= lsfp_pkg::CH_ONE) && (prev_c[7:0] <= lsfp_pkg::CH_EIGHT) &&
               ((found_c & new_bit) == '0);

    in_frame_nxt = in_frame_c;
    idx_nxt      = idx_c;
    prefix_nxt   = prefix_c;
    ended_nxt    = ended_c;
    prev_nxt     = prev_c;
    found_nxt    = found_c;
    zero_nxt     = zero_c;
    bad_nxt      = bad_c;
    phase_nxt    = phase_c;
    key_nxt      = key_c;
    nz_nxt       = nz_c;
    end_num      = 1'b0;
    emit         = 1'b0;

    if (in_frame_c) begin
      if (idx_c >= lsfp_pkg::IDX_W'(lsfp_pkg::FRAME_BYTES - 1)) begin
        // overlong: drop the frame, this byte included
        in_frame_nxt = 1'b0;
        idx_nxt      = '0;
      end else begin
        if ((idx_c == lsfp_pkg::IDX_W'(1) && rx_byte != lsfp_pkg::CH_D) ||
            (idx_c == lsfp_pkg::IDX_W'(2) && rx_byte != lsfp_pkg::CH_COMMA)) begin
          prefix_nxt = 1'b0;
        end
        if (!ended_c) begin
          if (rx_byte == lsfp_pkg::CH_NUL) begin
            ended_nxt = 1'b1;
            end_num   = (phase_c != lsfp_pkg::PH_IDLE);
          end else begin
            if (phase_c == lsfp_pkg::PH_PRE && is_ws) begin
              // leading whitespace, keep waiting
            end else if (phase_c == lsfp_pkg::PH_PRE && is_sign) begin
              phase_nxt = lsfp_pkg::PH_SIGN;
            end else if (phase_c != lsfp_pkg::PH_IDLE) begin
              if (is_digit) begin
                phase_nxt = lsfp_pkg::PH_DIGIT;
                nz_nxt    = nz_c | (rx_byte != lsfp_pkg::CH_ZERO);
              end else begin
                end_num = 1'b1;
              end
            end
            prev_nxt = {prev_c[7:0], rx_byte};
          end
        end
        if (end_num) begin
          if (phase_c == lsfp_pkg::PH_PRE || phase_c == lsfp_pkg::PH_SIGN) begin
            bad_nxt = bad_c | act_bit;
          end else if (phase_c == lsfp_pkg::PH_DIGIT && !nz_c) begin
            zero_nxt = zero_c | act_bit;
          end
          phase_nxt = lsfp_pkg::PH_IDLE;
        end
        if (key_hit) begin
          found_nxt = found_c | new_bit;
          key_nxt   = new_key;
          nz_nxt    = 1'b0;
          phase_nxt = lsfp_pkg::PH_PRE;
        end
        idx_nxt = idx_c + 1'b1;
        if (rx_byte == lsfp_pkg::CH_HASH) begin
          emit         = 1'b1;
          in_frame_nxt = 1'b0;
          idx_nxt      = '0;
        end
      end
    end

    res.ok   = prefix_nxt && (&found_nxt) && (bad_nxt == '0);
    res.bits = res.ok ? zero_nxt : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      idx_r      <= '0;
      prefix_r   <= 1'b0;
      ended_r    <= 1'b0;
      prev_r     <= '0;
      found_r    <= '0;
      zero_r     <= '0;
      bad_r      <= '0;
      phase_r    <= lsfp_pkg::PH_IDLE;
      key_r      <= '0;
      nz_r       <= 1'b0;
    end else if (cmd.take) begin
      in_frame_r <= in_frame_nxt;
      idx_r      <= idx_nxt;
      prefix_r   <= prefix_nxt;
      ended_r    <= ended_nxt;
      prev_r     <= prev_nxt;
      found_r    <= found_nxt;
      zero_r     <= zero_nxt;
      bad_r      <= bad_nxt;
      phase_r    <= phase_nxt;
      key_r      <= key_nxt;
      nz_r       <= nz_nxt;
    end
  end

endmodule

### rtl/lsfp_div.sv
// Offset datapath: weight sum and set-bit count, a bit-per-cycle restoring
// divider and the output register. Uses lsfp_pkg; commanded by lsfp_ctrl.
`timescale 1ns / 1ps

module lsfp_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lsfp_pkg::ctrl_cmd_t  cmd,
  input  lsfp_pkg::frame_res_t res,
  input  logic                 out_stall,
  output logic                 out_free,
  output logic                 out_valid,
  output logic                 out_frame_ok,
  output logic [7:0]           out_sensor_bits,
  output logic signed [3:0]    out_line_offset
);

  logic                        ok_r;
  logic [7:0]                  bits_r;
  logic [lsfp_pkg::DIV_STEPS-1:0] num_r;   // dividend in, quotient out
  logic [2:0]                  rem_r;
  logic [3:0]                  den_r;
  logic                        neg_r;
  logic                        valid_r, valid_nxt;
  logic                        frame_ok_r;
  logic [7:0]                  sensor_bits_r;
  logic signed [3:0]           offset_r, offset_nxt;

  logic signed [5:0] sum;
  logic [3:0]        count;
  logic [5:0]        mag;
  logic [3:0]        trial;
  logic              qbit;
  logic [3:0]        q;

  always_comb begin
    sum   = '0;
    count = '0;
    for (int i = 0; i < 8; i++) begin
      if (bits_r[i]) begin
        sum   = sum + signed'({{2{lsfp_pkg::WEIGHT[i][3]}}, lsfp_pkg::WEIGHT[i]});
        count = count + 4'd1;
      end
    end
    mag = sum[5] ? 6'(-sum) : 6'(sum);

    trial = {rem_r, num_r[lsfp_pkg::DIV_STEPS-1]};
    qbit  = (trial >= den_r);

    q          = num_r[3:0];
    offset_nxt = (bits_r == '0) ? 4'sd0 : (neg_r ? signed'(4'(4'd0 - q)) : signed'(q));

    out_free  = !valid_r || !out_stall;
    valid_nxt = cmd.out_load ? 1'b1 : (out_stall ? valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      ok_r   <= res.ok;
      bits_r <= res.bits;
    end
    if (cmd.div_load) begin
      num_r <= mag[lsfp_pkg::DIV_STEPS-1:0];
      rem_r <= '0;
      den_r <= count;
      neg_r <= sum[5];
    end else if (cmd.div_step) begin
      num_r <= {num_r[lsfp_pkg::DIV_STEPS-2:0], qbit};
      rem_r <= qbit ? 3'(trial - den_r) : trial[2:0];
    end
    if (cmd.out_load) begin
      frame_ok_r    <= ok_r;
      sensor_bits_r <= bits_r;
      offset_r      <= offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_frame_ok    = frame_ok_r;
  assign out_sensor_bits = sensor_bits_r;
  assign out_line_offset = offset_r;

endmodule

### rtl/line_sensor_frame_parser.sv
// Line sensor frame parser: usage
// Input channel: one byte of the sensor's ASCII stream per request on in_rx_byte,
// taken at a rising edge with in_valid high and in_stall low. '$' opens a frame,
// '#' closes it; bytes outside a frame and overlong frames give no result.
// Result channel: out_frame_ok, out_sensor_bits, out_line_offset, taken at an edge
// with out_valid high and out_stall low. One result per closing '#'.
// Throughput: any byte that does not close a frame is taken every cycle.
// A closing byte starts the offset unit (sum/count load, then a five-step
// restoring divider, one quotient bit per cycle); in_stall stays high through
// the load, the division and the hand-off, which waits for a free output register.
// The output register holds one result: while the receiver stalls, further
// bytes are still taken; after a following '#' intake holds until it is freed.
// Reset (rst_n low, synchronous) drops any partial frame and empties the
// output register; bytes are ignored until the next '$'.
// Uses lsfp_pkg, lsfp_ctrl, lsfp_parse and lsfp_div.
`timescale 1ns / 1ps

module line_sensor_frame_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_frame_ok,
  output logic [7:0]        out_sensor_bits,
  output logic signed [3:0] out_line_offset
);

  lsfp_pkg::ctrl_cmd_t  cmd;
  lsfp_pkg::ctrl_stat_t stat;
  lsfp_pkg::frame_res_t res;
  logic                 emit;
  logic                 out_free;

  assign stat.emit     = emit;
  assign stat.out_free = out_free;

  lsfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  lsfp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rx_byte (in_rx_byte),
    .emit    (emit),
    .res     (res)
  );

  lsfp_div u_div (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .res             (res),
    .out_stall       (out_stall),
    .out_free        (out_free),
    .out_valid       (out_valid),
    .out_frame_ok    (out_frame_ok),
    .out_sensor_bits (out_sensor_bits),
    .out_line_offset (out_line_offset)
  );

  // a closing byte must hold off intake while the offset is computed
  a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && emit) |=> in_stall)
    else $error("byte taken right after a closing byte");

  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_line_offset != 4'sb1000))
    else $error("line offset out of range");

  a_bad_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_frame_ok) |-> (out_sensor_bits == '0 && out_line_offset == 4'sd0))
    else $error("malformed frame carries data");

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result appeared without a load");

endmodule

### verif/line_sensor_frame_parser_tb.sv
// Self-checking bench for line_sensor_frame_parser: a byte stream of sensor frames,
// broken frames and noise goes in; each closed frame's verdict is predicted and checked.
// Depends on lsfp_pkg and the line_sensor_frame_parser RTL.
`timescale 1ns / 1ps

module line_sensor_frame_parser_tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int QUIET_TAIL  = 150;   // last requests go in with no idling on either side
  localparam int MIN_BYTES   = 1600;
  localparam int MIN_FRAMES  = 20;
  localparam int DRAIN       = 20;

  // zero patterns that give every kind of offset, truncation included
  localparam logic [7:0] OFFSET_MASKS [6] = '{8'h00, 8'h01, 8'h80, 8'h13, 8'hC8, 8'hFF};

  typedef enum int {
    SHAPE_CLEAN, SHAPE_REPEAT, SHAPE_BAD_BYTE, SHAPE_NUL, SHAPE_BAD_PREFIX,
    SHAPE_MISSING_KEY, SHAPE_NO_DIGITS, SHAPE_RESTART, SHAPE_NOISE, SHAPE_STRAY,
    SHAPE_OVERLONG, SHAPE_BOUNDARY
  } frame_shape_t;

  typedef struct packed {
    logic              ok;
    logic [7:0]        bits;
    logic signed [3:0] offset;
  } frame_verdict_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_rx_byte = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_frame_ok;
  logic [7:0]        out_sensor_bits;
  logic signed [3:0] out_line_offset;

  line_sensor_frame_parser u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_ok    (out_frame_ok),
    .out_sensor_bits (out_sensor_bits),
    .out_line_offset (out_line_offset)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  logic [7:0]     pending_bytes [$];
  logic [7:0]     frame_buf [$];
  frame_verdict_t expected_frames [$];

  int frames_built = 0;
  int total_bytes = 0;
  int bytes_taken = 0;
  int results_checked = 0;
  int valid_seen = 0;
  int failures = 0;
  int cycle_count = 0;
  int feed_gap = 0;
  int feed_calm = 0;
  int sink_hold = 0;
  int sink_calm = 0;

  // ---------------------------------------------------------------- predictor state
  logic        rx_in_frame = 1'b0;
  int          rx_kept = 0;
  logic        rx_hdr_ok = 1'b0;
  logic        rx_text_done = 1'b0;
  logic [15:0] rx_last_two = '0;
  logic [7:0]  rx_keys_seen = '0;
  logic [7:0]  rx_keys_zero = '0;
  logic [7:0]  rx_keys_bad = '0;
  logic [1:0]  rx_phase = lsfp_pkg::PH_IDLE;
  logic [2:0]  rx_key = '0;
  logic        rx_nonzero = 1'b0;

  function automatic void finish_number();
    if (rx_phase == lsfp_pkg::PH_PRE || rx_phase == lsfp_pkg::PH_SIGN)
      rx_keys_bad[rx_key] = 1'b1;
    else if (rx_phase == lsfp_pkg::PH_DIGIT && !rx_nonzero)
      rx_keys_zero[rx_key] = 1'b1;
    rx_phase = lsfp_pkg::PH_IDLE;
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    logic [2:0] k;
    logic       is_ws;
    logic       is_sign;
    if (rx_text_done) return;
    if (c == lsfp_pkg::CH_NUL) begin
      if (rx_phase != lsfp_pkg::PH_IDLE) finish_number();
      rx_text_done = 1'b1;
      return;
    end
    is_ws = (c == lsfp_pkg::CH_SPACE) || (c >= lsfp_pkg::CH_TAB && c <= lsfp_pkg::CH_CR);
    is_sign = (c == lsfp_pkg::CH_PLUS) || (c == lsfp_pkg::CH_MINUS);
    if (rx_phase == lsfp_pkg::PH_PRE && is_sign) begin
      rx_phase = lsfp_pkg::PH_SIGN;
    end else if (rx_phase != lsfp_pkg::PH_IDLE &&
                 !(rx_phase == lsfp_pkg::PH_PRE && is_ws)) begin
      if (c >= lsfp_pkg::CH_ZERO && c <= lsfp_pkg::CH_NINE) begin
        rx_phase = lsfp_pkg::PH_DIGIT;
        if (c != lsfp_pkg::CH_ZERO) rx_nonzero = 1'b1;
      end else begin
        finish_number();
      end
    end
    if (c == lsfp_pkg::CH_COLON && rx_last_two[15:8] == lsfp_pkg::CH_X &&
        rx_last_two[7:0] >= lsfp_pkg::CH_ONE && rx_last_two[7:0] <= lsfp_pkg::CH_EIGHT) begin
      // '1'..'8' map onto key 0..7 through the low three bits
      k = rx_last_two[2:0] - 3'd1;
      if (!rx_keys_seen[k]) begin
        rx_keys_seen[k] = 1'b1;
        rx_key = k;
        rx_nonzero = 1'b0;
        rx_phase = lsfp_pkg::PH_PRE;
      end
    end
    rx_last_two = {rx_last_two[7:0], c};
  endfunction

  // Returns 1 when the byte closes a frame, with the verdict in v.
  function automatic logic predict_frame_byte(logic [7:0] c, output frame_verdict_t v);
    int sum;
    int cnt;
    int off;
    sum = 0;
    cnt = 0;
    off = 0;
    v = '0;
    if (c == lsfp_pkg::CH_DOLLAR) begin
      rx_in_frame = 1'b1;
      rx_kept = 0;
      rx_hdr_ok = 1'b1;
      rx_text_done = 1'b0;
      rx_last_two = '0;
      rx_keys_seen = '0;
      rx_keys_zero = '0;
      rx_keys_bad = '0;
      rx_phase = lsfp_pkg::PH_IDLE;
      rx_key = '0;
      rx_nonzero = 1'b0;
    end
    if (!rx_in_frame) return 1'b0;
    if (rx_kept >= lsfp_pkg::FRAME_BYTES - 1) begin
      rx_in_frame = 1'b0;
      rx_kept = 0;
      return 1'b0;
    end
    if ((rx_kept == 1 && c != lsfp_pkg::CH_D) || (rx_kept == 2 && c != lsfp_pkg::CH_COMMA))
      rx_hdr_ok = 1'b0;
    scan_byte(c);
    rx_kept++;
    if (c != lsfp_pkg::CH_HASH) return 1'b0;
    v.ok = rx_hdr_ok && rx_keys_seen == 8'hFF && rx_keys_bad == 8'h00;
    v.bits = v.ok ? rx_keys_zero : 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (v.bits[i]) begin
        sum += 2 * i - 7;
        cnt++;
      end
    end
    if (cnt != 0) off = sum / cnt;
    v.offset = off[3:0];
    rx_in_frame = 1'b0;
    rx_kept = 0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic logic [7:0] rand_byte(int lo, int hi);
    int r;
    r = $urandom_range(hi, lo);
    return r[7:0];
  endfunction

  function automatic void push_char(logic [7:0] c);
    frame_buf.push_back(c);
  endfunction

  // "$D," and the eight keys in random order with random formatting, then '#'.
  // skip_key is left out, blank_key gets no digits, pad_to (when set) is the frame length.
  task automatic build_sensor_frame(logic [7:0] zero_mask, int skip_key, int blank_key,
                                    logic add_repeat, int pad_to);
    int order [8];
    int j;
    int t;
    int n;
    int nz_pos;
    int code;
    push_char(lsfp_pkg::CH_DOLLAR);
    push_char(lsfp_pkg::CH_D);
    push_char(lsfp_pkg::CH_COMMA);
    for (int i = 0; i < 8; i++) order[i] = i;
    for (int i = 7; i > 0; i--) begin
      j = $urandom_range(i, 0);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < 8; i++) begin
      if (order[i] != skip_key) begin
        if (i != 0) begin
          case ($urandom_range(2, 0))
            0: push_char(lsfp_pkg::CH_COMMA);
            1: push_char(lsfp_pkg::CH_SPACE);
            default: push_char(lsfp_pkg::CH_TAB);
          endcase
        end
        code = lsfp_pkg::CH_ONE + order[i];
        push_char(lsfp_pkg::CH_X);
        push_char(code[7:0]);
        push_char(lsfp_pkg::CH_COLON);
        if (order[i] == blank_key) begin
          case ($urandom_range(3, 0))
            0: ;
            1: push_char(lsfp_pkg::CH_MINUS);
            2: begin
              push_char(lsfp_pkg::CH_TAB);
              push_char(lsfp_pkg::CH_PLUS);
            end
            default: begin
              push_char(lsfp_pkg::CH_PLUS);
              push_char(lsfp_pkg::CH_SPACE);
            end
          endcase
        end else begin
          if ($urandom_range(3, 0) == 0)
            push_char($urandom_range(1, 0) ? lsfp_pkg::CH_SPACE : rand_byte(9, 13));
          if ($urandom_range(3, 0) == 0)
            push_char($urandom_range(1, 0) ? lsfp_pkg::CH_PLUS : lsfp_pkg::CH_MINUS);
          n = $urandom_range(3, 1);
          nz_pos = $urandom_range(n - 1, 0);
          for (int d = 0; d < n; d++) begin
            if (zero_mask[order[i]])
              push_char(lsfp_pkg::CH_ZERO);
            else if (d == nz_pos)
              push_char(rand_byte(lsfp_pkg::CH_ONE, lsfp_pkg::CH_NINE));
            else
              push_char(rand_byte(lsfp_pkg::CH_ZERO, lsfp_pkg::CH_NINE));
          end
        end
      end
    end
    if (add_repeat) begin
      // a later copy of a key must not override the first one
      code = lsfp_pkg::CH_ONE + $urandom_range(7, 0);
      push_char(lsfp_pkg::CH_COMMA);
      push_char(lsfp_pkg::CH_X);
      push_char(code[7:0]);
      push_char(lsfp_pkg::CH_COLON);
      push_char(rand_byte(lsfp_pkg::CH_ZERO, lsfp_pkg::CH_NINE));
    end
    while (frame_buf.size() < pad_to - 1) push_char(lsfp_pkg::CH_SPACE);
    push_char(lsfp_pkg::CH_HASH);
  endtask

  task automatic emit_frame(frame_shape_t shape, logic [7:0] zero_mask);
    int p;
    frame_buf.delete();
    case (shape)
      SHAPE_REPEAT: build_sensor_frame(zero_mask, -1, -1, 1'b1, 0);
      SHAPE_BAD_BYTE: begin
        build_sensor_frame(zero_mask, -1, -1, 1'b0, 0);
        p = $urandom_range(frame_buf.size() - 2, 1);
        frame_buf[p] = rand_byte(0, 255);
      end
      SHAPE_NUL: begin
        build_sensor_frame(zero_mask, -1, -1, 1'b0, 0);
        p = $urandom_range(frame_buf.size() - 1, 1);
        frame_buf.insert(p, lsfp_pkg::CH_NUL);
      end
      SHAPE_BAD_PREFIX: begin
        build_sensor_frame(zero_mask, -1, -1, 1'b0, 0);
        frame_buf[$urandom_range(2, 1)] = rand_byte(0, 255);
      end
      SHAPE_MISSING_KEY: build_sensor_frame(zero_mask, $urandom_range(7, 0), -1, 1'b0, 0);
      SHAPE_NO_DIGITS: build_sensor_frame(zero_mask, -1, $urandom_range(7, 0), 1'b0, 0);
      SHAPE_RESTART: begin
        // a frame cut short by the next '$'
        push_char(lsfp_pkg::CH_DOLLAR);
        repeat ($urandom_range(12, 1))
          push_char(rand_byte(lsfp_pkg::CH_DOLLAR + 1, 255));
        build_sensor_frame(zero_mask, -1, -1, 1'b0, 0);
      end
      SHAPE_NOISE: repeat ($urandom_range(30, 1)) push_char(rand_byte(0, 255));
      SHAPE_STRAY: begin
        push_char(8'hFF);
        push_char(lsfp_pkg::CH_NUL);
        push_char(lsfp_pkg::CH_X);
        push_char(lsfp_pkg::CH_ONE);
        push_char(lsfp_pkg::CH_COLON);
        push_char(lsfp_pkg::CH_ZERO);
        push_char(lsfp_pkg::CH_HASH);
      end
      SHAPE_OVERLONG: begin
        // closing '#' lands past the length limit; the stray '#' after it is ignored
        build_sensor_frame(zero_mask, -1, -1, 1'b0,
                           $urandom_range(lsfp_pkg::FRAME_BYTES + 12,
                                          lsfp_pkg::FRAME_BYTES));
        push_char(lsfp_pkg::CH_HASH);
      end
      SHAPE_BOUNDARY: begin
        build_sensor_frame(zero_mask, -1, -1, 1'b0, lsfp_pkg::FRAME_BYTES - 1);
        push_char(lsfp_pkg::CH_HASH);
      end
      default: build_sensor_frame(zero_mask, -1, -1, $urandom_range(4, 0) == 0, 0);
    endcase
    foreach (frame_buf[i]) pending_bytes.push_back(frame_buf[i]);
    if (shape != SHAPE_NOISE && shape != SHAPE_STRAY) frames_built++;
  endtask

  // ---------------------------------------------------------------- input side
  always @(posedge clk) begin : feed_side
    frame_verdict_t v;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        bytes_taken++;
        if (predict_frame_byte(in_rx_byte, v)) expected_frames.push_back(v);
      end
      if (!in_valid || !in_stall) begin
        if (feed_gap > 0) begin
          feed_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_rx_byte <= pending_bytes.pop_front();
          if (pending_bytes.size() > QUIET_TAIL) begin
            if (feed_calm > 0) feed_calm--;
            else if ($urandom_range(9, 0) == 0) feed_gap = $urandom_range(18, 1);
            else if ($urandom_range(39, 0) == 0) feed_calm = $urandom_range(120, 20);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- result side
  always @(posedge clk) begin : sink_side
    frame_verdict_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $error("result with no closed frame pending: frame_ok %0d bits %h offset %0d",
               out_frame_ok, out_sensor_bits, out_line_offset);
        failures++;
      end else begin
        want = expected_frames.pop_front();
        results_checked++;
        if (want.ok) valid_seen++;
        if (out_frame_ok !== want.ok) begin
          $error("frame_ok: expected %0d, got %0d", want.ok, out_frame_ok);
          failures++;
        end
        if (out_sensor_bits !== want.bits) begin
          $error("sensor_bits: expected %h, got %h", want.bits, out_sensor_bits);
          failures++;
        end
        if (out_line_offset !== want.offset) begin
          $error("line_offset: expected %0d, got %0d", want.offset, out_line_offset);
          failures++;
        end
      end
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (pending_bytes.size() <= QUIET_TAIL) begin
      out_stall <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      out_stall <= 1'b1;
    end else if (sink_calm > 0) begin
      sink_calm--;
      out_stall <= 1'b0;
    end else if ($urandom_range(7, 0) == 0) begin
      sink_hold = $urandom_range(17, 0);
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(49, 0) == 0) sink_calm = $urandom_range(150, 30);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles: %0d of %0d bytes taken, %0d results outstanding",
               cycle_count, bytes_taken, total_bytes, expected_frames.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int pick;
    frame_shape_t shape;

    // directed: stray bytes, each offset case, a repeated key, every malformed kind and a frame at the limit
    emit_frame(SHAPE_STRAY, 8'h00);
    foreach (OFFSET_MASKS[i]) emit_frame(SHAPE_CLEAN, OFFSET_MASKS[i]);
    emit_frame(SHAPE_REPEAT, 8'h66);
    emit_frame(SHAPE_NO_DIGITS, 8'h5A);
    emit_frame(SHAPE_MISSING_KEY, 8'h3C);
    emit_frame(SHAPE_NUL, 8'hA5);
    emit_frame(SHAPE_BAD_PREFIX, 8'hFF);
    emit_frame(SHAPE_BAD_BYTE, 8'h42);
    emit_frame(SHAPE_RESTART, 8'h81);
    emit_frame(SHAPE_BOUNDARY, 8'hF0);
    emit_frame(SHAPE_OVERLONG, 8'h0F);
    emit_frame(SHAPE_NOISE, 8'h00);

    // random: mostly well-formed frames, the rest broken frames and noise
    while (pending_bytes.size() < MIN_BYTES || frames_built < MIN_FRAMES) begin
      pick = $urandom_range(99, 0);
      if (pick < 40) shape = SHAPE_CLEAN;
      else if (pick < 45) shape = SHAPE_REPEAT;
      else if (pick < 52) shape = SHAPE_BAD_BYTE;
      else if (pick < 57) shape = SHAPE_NUL;
      else if (pick < 62) shape = SHAPE_BAD_PREFIX;
      else if (pick < 68) shape = SHAPE_MISSING_KEY;
      else if (pick < 74) shape = SHAPE_NO_DIGITS;
      else if (pick < 79) shape = SHAPE_RESTART;
      else if (pick < 87) shape = SHAPE_NOISE;
      else if (pick < 90) shape = SHAPE_STRAY;
      else if (pick < 94) shape = SHAPE_OVERLONG;
      else shape = SHAPE_BOUNDARY;
      emit_frame(shape, rand_byte(0, 255));
    end
    total_bytes = pending_bytes.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < total_bytes) @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("stream of %0d bytes over %0d frames; %0d results compared, %0d valid frames",
             total_bytes, frames_built, results_checked, valid_seen);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
